// ----- src/tcc_pkg.sv -----
// Shared types and calibration constants for the touch coordinate conditioner.
`default_nettype none

package tcc_pkg;

    localparam int RAW_W  = 12;
    localparam int X_W    = 8;
    localparam int Y_W    = 9;
    localparam int DB_W   = 10;
    localparam int DIST_W = 10;

    localparam logic [RAW_W-1:0] X_SPLIT    = 12'd3000;
    localparam logic [RAW_W-1:0] X_OFS_LO   = 12'd3870;
    localparam logic [RAW_W-1:0] X_OFS_HI   = 12'd3800;
    localparam logic [RAW_W-1:0] Y_OFS      = 12'd360;

    // Reciprocals scaled by 2^16, exact for 12-bit dividends.
    localparam int               RECIP_SHIFT = 16;
    localparam int               PROD_W      = 25;
    localparam logic [12:0]      X_RECIP     = 13'd4370;
    localparam logic [12:0]      Y_RECIP     = 13'd5958;

    localparam logic [8:0]       X_LIMIT     = 9'd240;
    localparam logic [X_W-1:0]   X_MAX       = 8'd239;
    localparam logic [8:0]       Y_LIMIT     = 9'd320;
    localparam logic [Y_W-1:0]   Y_MAX       = 9'd319;

    localparam logic [DB_W-1:0]  DEADBAND_RST = 10'd5;

    typedef struct packed {
        logic             touch;
        logic [RAW_W-1:0] raw_x;
        logic [RAW_W-1:0] raw_y;
    } t_sample;

    typedef struct packed {
        logic           touch;
        logic [X_W-1:0] x;
        logic [Y_W-1:0] y;
    } t_cal;

    typedef struct packed {
        logic           pressed;
        logic           rejected;
        logic [X_W-1:0] pos_x;
        logic [Y_W-1:0] pos_y;
    } t_result;

endpackage

`default_nettype wire

// ----- src/tcc_calib.sv -----
// Raw reading to screen pixel calibration for X and Y.
`default_nettype none

module tcc_calib (
    input  wire tcc_pkg::t_sample i_sample,
    output tcc_pkg::t_cal         o_cal
);

    logic [tcc_pkg::RAW_W-1:0]  x_num;
    logic [tcc_pkg::RAW_W-1:0]  y_num;
    logic [tcc_pkg::PROD_W-1:0] x_prod;
    logic [tcc_pkg::PROD_W-1:0] y_prod;
    logic [8:0]                 x_q;
    logic [8:0]                 y_q;

    always_comb begin
        if (i_sample.raw_x <= tcc_pkg::X_SPLIT) begin
            x_num = tcc_pkg::X_OFS_LO - i_sample.raw_x;
        end else if (i_sample.raw_x < tcc_pkg::X_OFS_HI) begin
            x_num = tcc_pkg::X_OFS_HI - i_sample.raw_x;
        end else begin
            x_num = '0;
        end
        if (i_sample.raw_y > tcc_pkg::Y_OFS) begin
            y_num = i_sample.raw_y - tcc_pkg::Y_OFS;
        end else begin
            y_num = '0;
        end
    end

    assign x_prod = tcc_pkg::PROD_W'(x_num) * tcc_pkg::PROD_W'(tcc_pkg::X_RECIP);
    assign y_prod = tcc_pkg::PROD_W'(y_num) * tcc_pkg::PROD_W'(tcc_pkg::Y_RECIP);
    assign x_q    = x_prod[tcc_pkg::RECIP_SHIFT+8:tcc_pkg::RECIP_SHIFT];
    assign y_q    = y_prod[tcc_pkg::RECIP_SHIFT+8:tcc_pkg::RECIP_SHIFT];

    always_comb begin
        o_cal.touch = i_sample.touch;
        o_cal.x     = (x_q >= tcc_pkg::X_LIMIT) ? tcc_pkg::X_MAX : x_q[tcc_pkg::X_W-1:0];
        o_cal.y     = (y_q >= tcc_pkg::Y_LIMIT) ? tcc_pkg::Y_MAX : y_q;
    end

endmodule

`default_nettype wire

// ----- src/tcc_filter.sv -----
// Edge rejection, deadband filter and held position registers.
`default_nettype none

module tcc_filter (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire [tcc_pkg::DB_W-1:0]      i_cfg_data,
    input  wire                          i_load,
    input  wire tcc_pkg::t_cal           i_cal,
    output tcc_pkg::t_result             o_result
);

    logic [tcc_pkg::DB_W-1:0]   r_deadband;
    logic [tcc_pkg::X_W-1:0]    r_held_x;
    logic [tcc_pkg::Y_W-1:0]    r_held_y;
    logic [tcc_pkg::X_W-1:0]    n_held_x;
    logic [tcc_pkg::Y_W-1:0]    n_held_y;
    logic [tcc_pkg::X_W-1:0]    dx;
    logic [tcc_pkg::Y_W-1:0]    dy;
    logic [tcc_pkg::DIST_W-1:0] manhattan;
    logic                       edge_hit;
    logic                       move;

    assign dx   = (i_cal.x > r_held_x) ? i_cal.x - r_held_x : r_held_x - i_cal.x;
    assign dy   = (i_cal.y > r_held_y) ? i_cal.y - r_held_y : r_held_y - i_cal.y;
    assign manhattan = tcc_pkg::DIST_W'(dx) + tcc_pkg::DIST_W'(dy);

    assign edge_hit = (i_cal.x == '0) || (i_cal.x == tcc_pkg::X_MAX)
                   || (i_cal.y == '0) || (i_cal.y == tcc_pkg::Y_MAX);
    assign move     = i_cal.touch && !edge_hit && (manhattan > r_deadband);

    assign n_held_x = move ? i_cal.x : r_held_x;
    assign n_held_y = move ? i_cal.y : r_held_y;

    always_comb begin
        o_result.pressed  = i_cal.touch;
        o_result.rejected = i_cal.touch && edge_hit;
        o_result.pos_x    = n_held_x;
        o_result.pos_y    = n_held_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadband <= tcc_pkg::DEADBAND_RST;
            r_held_x   <= '0;
            r_held_y   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_deadband <= i_cfg_data;
            end
            if (i_load) begin
                r_held_x <= n_held_x;
                r_held_y <= n_held_y;
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/touch_coordinate_conditioner.sv -----
// Top level: two-stage touch sample conditioning pipeline.
//
//  channel | direction | handshake               | payload
//  in      | input     | i_in_valid/o_in_stall   | i_touch_detected i_raw_x i_raw_y
//  out     | output    | o_out_valid/i_out_stall | o_pressed o_rejected o_pos_x o_pos_y
//  cfg     | input     | i_cfg_valid/o_cfg_ready | i_cfg_data (deadband)
//
// One sample per clock while i_out_stall is low; o_out_valid is the result register valid.
// Stages: input register, then calibration and filter in one pass into the result register.
// Held position updates when a sample moves into the result register and passes the filter.
// Synchronous active-low reset empties the pipe, sets deadband 5 and held position 0.
// i_out_stall backs up each full stage; o_in_stall rises only when both stages are full.
`default_nettype none

module touch_coordinate_conditioner (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_in_valid,
    output logic                        o_in_stall,
    input  wire                         i_touch_detected,
    input  wire [tcc_pkg::RAW_W-1:0]    i_raw_x,
    input  wire [tcc_pkg::RAW_W-1:0]    i_raw_y,
    output logic                        o_out_valid,
    input  wire                         i_out_stall,
    output logic                        o_pressed,
    output logic                        o_rejected,
    output logic [tcc_pkg::X_W-1:0]     o_pos_x,
    output logic [tcc_pkg::Y_W-1:0]     o_pos_y,
    input  wire                         i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire [tcc_pkg::DB_W-1:0]     i_cfg_data
);

    logic             r_v1;
    logic             r_v2;
    tcc_pkg::t_sample r_s1;
    tcc_pkg::t_result r_res;
    tcc_pkg::t_cal    cal;
    tcc_pkg::t_result res;
    logic             en1;
    logic             en2;

    assign en2 = !r_v2 || !i_out_stall;
    assign en1 = !r_v1 || en2;

    assign o_in_stall  = !en1;
    assign o_cfg_ready = 1'b1;

    tcc_calib u_calib (
        .i_sample (r_s1),
        .o_cal    (cal)
    );

    tcc_filter u_filter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_load     (en2 && r_v1),
        .i_cal      (cal),
        .o_result   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_in_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && i_in_valid) begin
            r_s1.touch <= i_touch_detected;
            r_s1.raw_x <= i_raw_x;
            r_s1.raw_y <= i_raw_y;
        end
        if (en2 && r_v1) begin
            r_res <= res;
        end
    end

    assign o_out_valid = r_v2;
    assign o_pressed   = r_res.pressed;
    assign o_rejected  = r_res.rejected;
    assign o_pos_x     = r_res.pos_x;
    assign o_pos_y     = r_res.pos_y;

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_v1 && r_v2 && i_out_stall))
        else $error("input stalled with an empty stage");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_pos_x <= tcc_pkg::X_MAX && o_pos_y <= tcc_pkg::Y_MAX))
        else $error("held position out of screen range");

    a_rej_pressed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_rejected) |-> o_pressed)
        else $error("rejected transaction without touch");

    a_rej_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en2 && r_v1 && r_v2 && res.rejected) |=>
        (o_pos_x == $past(r_res.pos_x) && o_pos_y == $past(r_res.pos_y)))
        else $error("rejected sample moved the held position");

endmodule

`default_nettype wire
